### src/asip_pkg.sv
// Shared constants, codes and controller/datapath interface types for the injector pulse core.
package asip_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int NUM_CHANNELS_DEF = 3;

  // field widths
  localparam int REQ_W   = 2;
  localparam int CH_W    = 2;
  localparam int ANGLE_W = 14;
  localparam int OPEN_W  = 16;
  localparam int TPT_W   = 24;
  localparam int TPU_W   = 8;
  localparam int DRIVE_W = 3;

  // derived arithmetic widths
  localparam int DIFF_W   = ANGLE_W + 1;
  localparam int PROD_W   = DIFF_W + TPT_W;
  localparam int OTICK_W  = OPEN_W + TPU_W;
  localparam int REM_W    = ANGLE_W + 1;
  localparam int DCNT_W   = $clog2(PROD_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_ANGLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US  = 2'd2;

  localparam logic [ANGLE_W-1:0] CYCLE_ANGLE_RST   = 14'd11520;
  localparam logic [ANGLE_W-1:0] TRIGGER_ANGLE_RST = 14'd96;
  localparam logic [TPU_W-1:0]   TICKS_PER_US_RST  = 8'd84;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PREPARE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  typedef struct packed {
    logic start;     // enable channel, start counter
    logic tick;      // advance the one-shot
    logic latch;     // capture prepare operands
    logic res_load;  // load result from the accepted beat
    logic mul;       // form product and open ticks, seed divider
    logic div_step;  // one restoring division step
    logic commit;    // store period and compare, zero result
  } cmd_t;

  typedef struct packed {
    logic reject;    // prepare beat has an angle out of range
  } status_t;

endpackage

### src/asip_ctrl.sv
// Controller state machine: handshakes, request decode and prepare sequencing.
module asip_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [asip_pkg::REQ_W-1:0] req_type,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  asip_pkg::status_t         status,
  output asip_pkg::cmd_t            cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state, state_next;
  logic [asip_pkg::DCNT_W-1:0] cnt, cnt_next;
  logic                        out_valid_next;
  logic                        out_free;
  logic                        accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            asip_pkg::REQ_PREPARE: begin
              cmd.latch = 1'b1;
              if (status.reject) begin
                cmd.res_load   = 1'b1;
                out_valid_next = 1'b1;
              end else begin
                state_next = S_MUL;
              end
            end
            asip_pkg::REQ_START: begin
              cmd.start      = 1'b1;
              cmd.res_load   = 1'b1;
              out_valid_next = 1'b1;
            end
            asip_pkg::REQ_TICK: begin
              cmd.tick       = 1'b1;
              cmd.res_load   = 1'b1;
              out_valid_next = 1'b1;
            end
            default: begin
              cmd.res_load   = 1'b1;
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = asip_pkg::DCNT_W'(asip_pkg::PROD_W - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/asip_dp.sv
// Datapath: config registers, one-shot counter, channel compares, multiply and divider.
module asip_dp #(
  parameter int COUNT_WIDTH  = asip_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_CHANNELS = asip_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [asip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [asip_pkg::CH_W-1:0]       channel,
  input  logic [asip_pkg::ANGLE_W-1:0]    inject_angle,
  input  logic [asip_pkg::ANGLE_W-1:0]    start_angle,
  input  logic [asip_pkg::OPEN_W-1:0]     open_time_us,
  input  logic [asip_pkg::TPT_W-1:0]      ticks_per_trigger,
  input  asip_pkg::cmd_t                  cmd,
  output asip_pkg::status_t               status,
  output logic [asip_pkg::DRIVE_W-1:0]    injector_drive,
  output logic                            pulse_done,
  output logic                            rejected
);

  localparam int TOT_W = ((COUNT_WIDTH > asip_pkg::OTICK_W) ? COUNT_WIDTH
                                                              : asip_pkg::OTICK_W) + 1;
  localparam int DRV_W = (NUM_CHANNELS > asip_pkg::DRIVE_W) ? NUM_CHANNELS
                                                              : asip_pkg::DRIVE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // configuration
  logic [asip_pkg::ANGLE_W-1:0] cycle_angle;
  logic [asip_pkg::ANGLE_W-1:0] trigger_angle;
  logic [asip_pkg::TPU_W-1:0]   ticks_per_us;

  // timer state
  logic [COUNT_WIDTH-1:0]  tick_count;
  logic [COUNT_WIDTH-1:0]  period_end;
  logic [COUNT_WIDTH-1:0]  channel_compare [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] channel_enable;
  logic                    running;

  // prepare operands and arithmetic
  logic [asip_pkg::CH_W-1:0]    op_ch;
  logic [asip_pkg::DIFF_W-1:0]  op_diff;
  logic [asip_pkg::OPEN_W-1:0]  op_open;
  logic [asip_pkg::TPT_W-1:0]   op_tpt;
  logic [asip_pkg::OTICK_W-1:0] open_ticks;
  logic [asip_pkg::PROD_W-1:0]  quot;
  logic [asip_pkg::REM_W-1:0]   rem;

  logic [asip_pkg::DIFF_W-1:0]  diff;
  logic [asip_pkg::PROD_W-1:0]  prod;
  logic [asip_pkg::OTICK_W-1:0] open_prod;
  logic [asip_pkg::REM_W-1:0]   rem_sh;
  logic                         rem_ge;
  logic [COUNT_WIDTH-1:0]       delay_sat;
  logic [TOT_W-1:0]             total;
  logic [TOT_W-1:0]             total_m1;
  logic [COUNT_WIDTH-1:0]       period;
  logic [NUM_CHANNELS-1:0]      tick_drive;
  logic [DRV_W-1:0]             drive_ext;
  logic                         tick_end;

  assign status.reject = (inject_angle > cycle_angle) || (start_angle > cycle_angle);

  // forward circular difference within the engine cycle
  always_comb begin
    if (inject_angle >= start_angle) begin
      diff = asip_pkg::DIFF_W'(inject_angle) - asip_pkg::DIFF_W'(start_angle);
    end else begin
      diff = asip_pkg::DIFF_W'(inject_angle) + asip_pkg::DIFF_W'(cycle_angle)
           - asip_pkg::DIFF_W'(start_angle);
    end
  end

  assign prod      = op_diff * op_tpt;
  assign open_prod = op_open * ticks_per_us;

  // restoring divide step; a zero divisor yields all ones, which saturates
  assign rem_sh = {rem[asip_pkg::REM_W-2:0], quot[asip_pkg::PROD_W-1]};
  assign rem_ge = rem_sh >= asip_pkg::REM_W'(trigger_angle);

  always_comb begin
    delay_sat = (|quot[asip_pkg::PROD_W-1:COUNT_WIDTH]) ? CNT_MAX : quot[COUNT_WIDTH-1:0];
    total     = TOT_W'(delay_sat) + TOT_W'(open_ticks);
    total_m1  = total - 1'b1;
    if (total == '0) begin
      period = '0;
    end else if (|total_m1[TOT_W-1:COUNT_WIDTH]) begin
      period = CNT_MAX;
    end else begin
      period = total_m1[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      tick_drive[i] = channel_enable[i] && (tick_count >= channel_compare[i]);
    end
  end
  assign tick_end  = tick_count >= period_end;
  assign drive_ext = DRV_W'(tick_drive);

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_angle    <= asip_pkg::CYCLE_ANGLE_RST;
      trigger_angle  <= asip_pkg::TRIGGER_ANGLE_RST;
      ticks_per_us   <= asip_pkg::TICKS_PER_US_RST;
      tick_count     <= '0;
      period_end     <= '0;
      channel_enable <= '0;
      running        <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_compare[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          asip_pkg::CFG_CYCLE_ANGLE:   cycle_angle   <= cfg_data;
          asip_pkg::CFG_TRIGGER_ANGLE: trigger_angle <= cfg_data;
          asip_pkg::CFG_TICKS_PER_US:  ticks_per_us  <= cfg_data[asip_pkg::TPU_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (int'(channel) == i) begin
            channel_enable[i] <= 1'b1;
          end
        end
        running <= 1'b1;
      end
      if (cmd.tick && running) begin
        if (tick_end) begin
          channel_enable <= '0;
          running        <= 1'b0;
          tick_count     <= '0;
        end else begin
          tick_count <= tick_count + 1'b1;
        end
      end
      if (cmd.commit) begin
        period_end <= period;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (int'(op_ch) == i) begin
            channel_compare[i] <= delay_sat;
          end
        end
      end
    end
  end

  // operands, divider and result beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_ch   <= channel;
      op_diff <= diff;
      op_open <= open_time_us;
      op_tpt  <= ticks_per_trigger;
    end
    if (cmd.mul) begin
      quot       <= prod;
      open_ticks <= open_prod;
      rem        <= '0;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_sh - asip_pkg::REM_W'(trigger_angle)) : rem_sh;
      quot <= {quot[asip_pkg::PROD_W-2:0], rem_ge};
    end
    if (cmd.res_load) begin
      injector_drive <= (cmd.tick && running) ? drive_ext[asip_pkg::DRIVE_W-1:0] : '0;
      pulse_done     <= cmd.tick && running && tick_end;
      rejected       <= cmd.latch && status.reject;
    end
    if (cmd.commit) begin
      injector_drive <= '0;
      pulse_done     <= 1'b0;
      rejected       <= 1'b0;
    end
  end

endmodule

### src/angle_scheduled_injector_pulse_core.sv
// Top level of the angle-scheduled injector pulse core: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one request beat: prepare, start or tick.
// Output channel (out_valid/out_ready) returns exactly one result beat per request:
// injector_drive and pulse_done for ticks, rejected for prepares, zeros otherwise.
// Start, tick and unused requests: result in the cycle after the input beat, and a new
// beat is taken every cycle while the receiver keeps out_ready high.
// Prepare: an out-of-range angle is answered in the cycle after the beat. Otherwise
// the block runs a multiply state, a 39-step restoring division by trigger_angle (one
// quotient bit a cycle) and a commit state that waits for a free result register;
// in_ready stays low until the result is committed.
// The result register holds a beat until taken; while it is full and out_ready is
// low, in_ready is low. Config writes (cfg_we) take effect at once; the user keeps them to idle only (unenforced).
// Reset (rst, synchronous) restores register defaults, clears counter, period,
// compares and enables, stops the one-shot and empties the output.
module angle_scheduled_injector_pulse_core #(
  parameter int COUNT_WIDTH  = asip_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_CHANNELS = asip_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [asip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [asip_pkg::REQ_W-1:0]      req_type,
  input  logic [asip_pkg::CH_W-1:0]       channel,
  input  logic [asip_pkg::ANGLE_W-1:0]    inject_angle,
  input  logic [asip_pkg::ANGLE_W-1:0]    start_angle,
  input  logic [asip_pkg::OPEN_W-1:0]     open_time_us,
  input  logic [asip_pkg::TPT_W-1:0]      ticks_per_trigger,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [asip_pkg::DRIVE_W-1:0]    injector_drive,
  output logic                            pulse_done,
  output logic                            rejected
);

  asip_pkg::cmd_t    cmd;
  asip_pkg::status_t status;

  asip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  asip_dp #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .channel           (channel),
    .inject_angle      (inject_angle),
    .start_angle       (start_angle),
    .open_time_us      (open_time_us),
    .ticks_per_trigger (ticks_per_trigger),
    .cmd               (cmd),
    .status            (status),
    .injector_drive    (injector_drive),
    .pulse_done        (pulse_done),
    .rejected          (rejected)
  );

endmodule
